### sv/assert_macros.svh
// assert_macros.svh: assertion macros shared by the set store modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each clock edge, ignoring cycles in reset.
`define USS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define USS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/uss_pkg.sv
// uss_pkg: shared constants and controller/datapath signal groups
// for the unsorted set store. No dependencies.
package uss_pkg;

  // Default number of stored entries
  localparam int CAPACITY_DEF = 64;

  // Width of the reported count field
  localparam int COUNT_W = 7;

  // Request operation codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CONFLICT = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;        // capture the request, restart the scan
    logic       scan;        // issue the next entry read, compare the last one
    logic       rd_last;     // read the last stored entry
    logic       wr_move;     // copy the last entry over the matching one, shrink
    logic       wr_ins;      // append the key, grow
    logic       set_status;  // latch the status code below
    logic [1:0] status;
    logic       out_load;    // load the result registers
  } uss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       hit;       // entry just read matches the key
    logic       scan_end;  // all stored entries compared, no match
    logic       full;      // no free entry left
    logic       found;     // key was seen during this scan
    logic [1:0] func;      // operation of the request in work
  } uss_status_t;

endpackage

### sv/uss_dp.sv
// uss_dp: datapath of the set store: entry memory, count, scan index,
// key and result registers. Depends on uss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uss_dp import uss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uss_cmd_t         cmd_i,
  output uss_status_t      stat_o,
  input  logic [1:0]       func_i,
  input  logic [31:0]      value_i,
  output logic             found_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [1:0]       status_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]   entries_q [CAPACITY];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] rd_tag_q, rd_tag_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  logic [31:0]   key_q;
  logic [1:0]    func_q;
  logic          found_q;
  logic [AW-1:0] pos_q;
  logic [1:0]    status_q;
  logic          out_found_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [1:0]    out_status_q;
  logic [31:0]   count_ext;

  logic          issue;
  logic          hit;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [31:0]   mem_wd;

  // Scan issue and compare
  assign count_m1 = count_q - CW'(1);
  assign issue    = cmd_i.scan && (idx_q < count_q);
  assign hit      = rd_vld_q && (rd_data_q == key_q);

  // Memory port selection
  always_comb begin
    mem_re = issue || cmd_i.rd_last;
    mem_ra = cmd_i.rd_last ? count_m1[AW-1:0] : idx_q[AW-1:0];
    mem_we = cmd_i.wr_ins || cmd_i.wr_move;
    mem_wa = cmd_i.wr_ins ? count_q[AW-1:0] : pos_q;
    mem_wd = cmd_i.wr_ins ? key_q : rd_data_q;
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= entries_q[mem_ra];
    end
  end

  // Next scan index, read tag and count
  always_comb begin
    idx_d    = idx_q;
    rd_vld_d = rd_vld_q;
    rd_tag_d = rd_tag_q;
    count_d  = count_q;
    if (cmd_i.load) begin
      idx_d    = '0;
      rd_vld_d = 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_d = issue;
      if (issue) begin
        idx_d    = idx_q + CW'(1);
        rd_tag_d = idx_q[AW-1:0];
      end
    end
    if (cmd_i.wr_ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.wr_move) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      count_q  <= '0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      count_q  <= count_d;
    end
  end

  // Hold request, match position and result payload
  always_ff @(posedge clk_i) begin
    rd_tag_q <= rd_tag_d;
    if (cmd_i.load) begin
      key_q   <= value_i;
      func_q  <= func_i;
      found_q <= 1'b0;
    end else if (cmd_i.scan && hit) begin
      found_q <= 1'b1;
      pos_q   <= rd_tag_q;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_found_q  <= found_q;
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_status_q <= status_q;
    end
  end

  assign count_ext = 32'(count_q);

  assign stat_o.hit      = hit;
  assign stat_o.scan_end = !rd_vld_q && (idx_q >= count_q);
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.found    = found_q;
  assign stat_o.func     = func_q;

  assign found_o  = out_found_q;
  assign count_o  = out_count_q;
  assign status_o = out_status_q;

  `USS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count above capacity")
  `USS_ASSERT(a_ins_grows, clk_i, rst_ni, cmd_i.wr_ins |=> count_q == $past(count_q) + CW'(1), "insert did not grow count")
  `USS_ASSERT(a_move_found, clk_i, rst_ni, cmd_i.wr_move |-> found_q && (count_q != '0), "remove without a match")

endmodule

### sv/uss_ctrl.sv
// uss_ctrl: request sequencer of the set store: scan, decide, write back,
// hand over the result. Depends on uss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uss_ctrl import uss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  uss_status_t stat_i,
  output uss_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Sequence one request at a time
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit || stat_i.scan_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = STATUS_OK;
        state_d          = S_FINISH;
        if (stat_i.func == FUNC_INSERT) begin
          if (stat_i.found) begin
            cmd_o.status = STATUS_CONFLICT;
          end else if (stat_i.full) begin
            cmd_o.status = STATUS_FULL;
          end else begin
            cmd_o.wr_ins = 1'b1;
          end
        end else if (stat_i.func == FUNC_REMOVE) begin
          if (!stat_i.found) begin
            cmd_o.status = STATUS_CONFLICT;
          end else begin
            cmd_o.rd_last = 1'b1;
            state_d       = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        cmd_o.wr_move = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `USS_ASSERT(a_finish_shows, clk_i, rst_ni, (state_q == S_FINISH && slot_free) |=> out_valid_q, "finished result not shown")
  `USS_ASSERT(a_hit_decides, clk_i, rst_ni, (state_q == S_SCAN && stat_i.hit) |=> state_q == S_DECIDE, "match did not end scan")
  `USS_ASSERT_ALWAYS(a_one_write, clk_i, !(cmd_o.wr_ins && cmd_o.wr_move), "two writes in one cycle")

endmodule

### sv/unsorted_set_store.sv
// unsorted_set_store: top level of the unordered set store of signed keys.
// Depends on uss_pkg, uss_ctrl and uss_dp.
//
//   channel  handshake                  payload
//   request  in_valid_i / in_ready_o    func_i[1:0], value_i[31:0]
//   result   out_valid_o / out_ready_i  found_o, count_o[6:0], status_o[1:0]
//
// A request is scanned, decided and written back before the next one is
// accepted; one stored entry is read per cycle through the single read port,
// and the scan stops at the first match.
// Reset clears the count, scan state, sequencer state and result valid; entry contents are left as they are.
// A finished result waits in its output register while the next request
// is taken; a stalled result delays only the finish of the following one.
module unsorted_set_store import uss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [1:0]         status_o
);

  uss_cmd_t    cmd;
  uss_status_t stat;

  // Sequencer
  uss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and compare
  uss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .func_i   (func_i),
    .value_i  (value_i),
    .found_o  (found_o),
    .count_o  (count_o),
    .status_o (status_o)
  );

endmodule

### test/tb_unsorted_set_store.sv
// tb_unsorted_set_store: self-checking testbench for the unordered set store.
// Predicts each request's result from its own copy of the set; needs uss_pkg
// and unsorted_set_store.
module tb_unsorted_set_store;
  timeunit 1ns;
  timeprecision 1ps;
  import uss_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int POOL_SIZE = 96;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } set_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = FUNC_LOOKUP;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               found_o;
  logic [COUNT_W-1:0] count_o;
  logic [1:0]         status_o;

  // Predicted set contents and pending results
  logic [31:0] set_keys [CAPACITY_DEF];
  int          set_size = 0;
  set_result_t pending_results [$];
  logic [31:0] key_pool [POOL_SIZE];

  int error_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_asked = 0;

  unsorted_set_store uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the predicted set and return its result
  function automatic set_result_t apply_request(logic [1:0] op, logic [31:0] key);
    set_result_t res;
    bit          present;
    int          pos;
    present = 1'b0;
    pos = 0;
    for (int i = 0; i < set_size; i++) begin
      if (!present && set_keys[i] == key) begin
        present = 1'b1;
        pos = i;
      end
    end
    res.status = STATUS_OK;
    case (op)
      FUNC_INSERT: begin
        if (present) res.status = STATUS_CONFLICT;
        else if (set_size >= CAPACITY_DEF) res.status = STATUS_FULL;
        else begin
          set_keys[set_size] = key;
          set_size++;
        end
      end
      FUNC_REMOVE: begin
        if (!present) res.status = STATUS_CONFLICT;
        else begin
          // swap the last entry into the hole
          set_keys[pos] = set_keys[set_size-1];
          set_size--;
        end
      end
      default: ;
    endcase
    res.found = present;
    res.count = COUNT_W'(set_size);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one request; entered and left just after a falling edge
  task automatic send_request(input logic [1:0] op, input logic [31:0] key);
    while (!tx_steady && $urandom_range(99) < 23) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = op;
    value_i = key;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(op, key));
    @(negedge clk_i);
  endtask

  // Hold the sender until every pending result has come back
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Drive result ready: random stalls, steady stretches, long hold-offs
  always @(negedge clk_i) begin : result_sink
    int hold_taken;
    int hold_left;
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else if (rx_steady) begin
      out_ready_i = 1'b1;
    end else begin
      out_ready_i = ($urandom_range(99) >= 23);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found)
          report_mismatch($sformatf("found %b, want %b", found_o, want.found));
        if (count_o !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", count_o, want.count));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Edge keys, zero, swap-remove and the unused operation code
  task automatic test_directed();
    send_request(FUNC_LOOKUP, 32'h0000_0000);
    send_request(FUNC_REMOVE, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_LOOKUP, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'h7FFF_FFFF);
    send_request(FUNC_INSERT, 32'h8000_0000);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'h0000_0001);
    send_request(FUNC_LOOKUP, 32'h8000_0000);
    send_request(FUNC_RESERVED, 32'h0000_0001);
    send_request(FUNC_RESERVED, 32'h0000_0002);
    send_request(FUNC_REMOVE, 32'h0000_0000);
    send_request(FUNC_LOOKUP, 32'h0000_0001);
    send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'hAAAA_AAAA);
    send_request(FUNC_INSERT, 32'h5555_5555);
    send_request(FUNC_LOOKUP, 32'h5555_5555);
    send_request(FUNC_REMOVE, 32'h7FFF_FFFF);
    send_request(FUNC_REMOVE, 32'h8000_0000);
    send_request(FUNC_REMOVE, 32'h0000_0001);
    send_request(FUNC_REMOVE, 32'hAAAA_AAAA);
    send_request(FUNC_REMOVE, 32'h5555_5555);
    send_request(FUNC_LOOKUP, 32'h5555_5555);
  endtask

  // Fill to capacity, probe the full store, then empty it in random order
  task automatic test_full_store();
    logic [31:0] key;
    while (set_size < CAPACITY_DEF) send_request(FUNC_INSERT, $urandom);
    send_request(FUNC_INSERT, $urandom);
    send_request(FUNC_INSERT, set_keys[$urandom_range(CAPACITY_DEF-1)]);
    send_request(FUNC_LOOKUP, set_keys[CAPACITY_DEF-1]);
    key = set_keys[0];
    send_request(FUNC_REMOVE, key);
    send_request(FUNC_INSERT, key);
    send_request(FUNC_INSERT, 32'h0000_0000);
    while (set_size > 0) send_request(FUNC_REMOVE, set_keys[$urandom_range(set_size-1)]);
  endtask

  // Pick a key: mostly from the shared pool or the set, sometimes anything
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return key_pool[$urandom_range(POOL_SIZE-1)];
    if (sel < 80 && set_size > 0) return set_keys[$urandom_range(set_size-1)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return FUNC_INSERT;
    if (sel < 75) return FUNC_REMOVE;
    if (sel < 95) return FUNC_LOOKUP;
    return FUNC_RESERVED;
  endfunction

  // Stall results for a long stretch while requests keep coming
  task automatic test_backpressure();
    tx_steady = 1'b1;
    hold_asked++;
    repeat (12) send_request(pick_op(), pick_key());
    tx_steady = 1'b0;
  endtask

  // Send a burst, pause the sender until the block has returned every result, then send another
  task automatic test_drain_pause();
    repeat (8) send_request(pick_op(), pick_key());
    wait_drained();
    @(negedge clk_i);
    repeat (8) send_request(pick_op(), pick_key());
  endtask

  task automatic test_random(input int n, input bit steady);
    tx_steady = steady;
    rx_steady = steady;
    repeat (n) send_request(pick_op(), pick_key());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Hold reset from the start, release on a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_store();
    test_backpressure();
    test_drain_pause();
    test_random(150, 1'b0);
    test_random(100, 1'b1);
    test_random(100, 1'b0);

    wait_drained();
    repeat (CAPACITY_DEF + 10) @(posedge clk_i);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/uss_pkg.sv
sv/uss_dp.sv
sv/uss_ctrl.sv
sv/unsorted_set_store.sv
test/tb_unsorted_set_store.sv
